// ===== sv/midpoint_line_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint line rasteriser
// Shared concurrent assertion forms, all sampled on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Checked outside reset only
`define MLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define MLR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Constants, codes and helpers shared by the midpoint line rasteriser.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS_DEF = 9;

    // Depth of the queue between front and back; a power of two
    localparam int QUEUE_DEPTH = 2;

    // Input item kind, carried on s_tuser
    localparam logic FUNC_START = 1'b0;

    typedef logic [2:0] zone_t;

    localparam zone_t ZONE_0 = 3'd0;
    localparam zone_t ZONE_1 = 3'd1;
    localparam zone_t ZONE_2 = 3'd2;
    localparam zone_t ZONE_3 = 3'd3;
    localparam zone_t ZONE_4 = 3'd4;
    localparam zone_t ZONE_5 = 3'd5;
    localparam zone_t ZONE_6 = 3'd6;
    localparam zone_t ZONE_7 = 3'd7;

    // Queue entry: kind, zone, three walk coordinates, three decision terms
    function automatic int entry_width(input int coord_bits);
        return 6 * coord_bits + 16;
    endfunction

endpackage

// ===== sv/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Eight-zone midpoint line rasteriser: one pixel per tick transaction.
// ----------------------------------------------------------------------------
//  channel  direction  transaction carries
//  s_*      in         func (tuser); start_x, start_y, end_x, end_y (tdata)
//  m_*      out        valid_res (tuser); pixel_x, pixel_y, octant (tdata); last
//
//  One transaction per cycle in and out while m_tready stays high; the per-pixel
//  step is coordinate increments, a decision-term add and one compare in the back,
//  fed from a queue of two entries. An input passes a queue entry, then the output register.
//  Reset empties the queue, drops any line in progress and clears m_tvalid.
//  A stall on m_tready holds the output register; the queue then fills and
//  s_tready falls once both queue entries are occupied.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8,
    localparam int ENTRY_W    = entry_width(COORD_BITS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, zero pad
    input  logic             s_tuser,   // func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // pixel_x, pixel_y, octant, zero pad
    output logic             m_tuser,   // valid_res
    output logic             m_tlast    // last
);

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mlr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front
// Classifies a start transaction into its zone, maps the endpoints into
// zone 0 and sets up the midpoint decision terms; ticks pass straight on.
// ----------------------------------------------------------------------------
module mlr_front
    import mlr_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int ENTRY_W    = entry_width(COORD_BITS)
)
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,    // start_x, start_y, end_x, end_y, zero pad
    input  logic               s_tuser,    // func
    output logic               push_valid,
    input  logic               push_ready,
    output logic [ENTRY_W-1:0] push_data
);

    localparam int CW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 3;

    typedef struct packed {
        logic                 kind;
        zone_t                zone;
        logic signed [CW-1:0] u0;
        logic signed [CW-1:0] v0;
        logic signed [CW-1:0] u1;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] east;
        logic signed [DW-1:0] diag;
    } entry_t;

    function automatic logic [2*CW-1:0] to_zone0(
        input zone_t                z,
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y
    );
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        case (z)
            ZONE_0:  begin u = x;  v = y;  end
            ZONE_1:  begin u = y;  v = x;  end
            ZONE_2:  begin u = y;  v = -x; end
            ZONE_3:  begin u = -x; v = y;  end
            ZONE_4:  begin u = -x; v = -y; end
            ZONE_5:  begin u = -y; v = -x; end
            ZONE_6:  begin u = -y; v = x;  end
            ZONE_7:  begin u = x;  v = -y; end
            default: begin u = x;  v = -y; end
        endcase
        return {u, v};
    endfunction

    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] ddx;
    logic signed [CW-1:0] ddy;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
    logic [CW-1:0]        dmax;
    logic [CW-1:0]        dmin;
    logic                 x_major;
    zone_t                zone;
    logic [2*CW-1:0]      map0;
    logic [2*CW-1:0]      map1;
    entry_t               entry;

    assign x0 = CW'(signed'(s_tdata[COORD_BITS-1:0]));
    assign y0 = CW'(signed'(s_tdata[2*COORD_BITS-1:COORD_BITS]));
    assign x1 = CW'(signed'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]));
    assign y1 = CW'(signed'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]));

    assign ddx = x1 - x0;
    assign ddy = y1 - y0;
    assign ax  = ddx[CW-1] ? CW'(-ddx) : ddx;
    assign ay  = ddy[CW-1] ? CW'(-ddy) : ddy;

    assign x_major = ax >= ay;
    assign dmax    = x_major ? ax : ay;
    assign dmin    = x_major ? ay : ax;

    always_comb
    begin
        if (x_major)
        begin
            if (!ddx[CW-1])
                zone = ddy[CW-1] ? ZONE_7 : ZONE_0;
            else
                zone = ddy[CW-1] ? ZONE_4 : ZONE_3;
        end
        else
        begin
            if (!ddx[CW-1])
                zone = ddy[CW-1] ? ZONE_6 : ZONE_1;
            else
                zone = ddy[CW-1] ? ZONE_5 : ZONE_2;
        end
    end

    assign map0 = to_zone0(zone, x0, y0);
    assign map1 = to_zone0(zone, x1, y1);

    // In zone 0 the run is the larger magnitude and the rise the smaller
    always_comb
    begin
        entry.kind = s_tuser;
        entry.zone = zone;
        entry.u0   = map0[2*CW-1:CW];
        entry.v0   = map0[CW-1:0];
        entry.u1   = map1[2*CW-1:CW];
        entry.east = {1'b0, dmin, 1'b0};
        entry.d0   = {1'b0, dmin, 1'b0} - {2'b00, dmax};
        entry.diag = {1'b0, dmin, 1'b0} - {1'b0, dmax, 1'b0};
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;
    assign push_data  = entry;

endmodule

// ===== sv/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mlr_queue
    import mlr_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back
// Walks the current line one pixel per transaction in zone 0, maps each
// pixel back to its own zone and holds it in the output register.
// ----------------------------------------------------------------------------
module mlr_back
    import mlr_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8,
    localparam int ENTRY_W    = entry_width(COORD_BITS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic [ENTRY_W-1:0] pop_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,    // pixel_x, pixel_y, octant, zero pad
    output logic               m_tuser,    // valid_res
    output logic               m_tlast     // last
);

    localparam int CW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 3;

    typedef struct packed {
        logic                 kind;
        zone_t                zone;
        logic signed [CW-1:0] u0;
        logic signed [CW-1:0] v0;
        logic signed [CW-1:0] u1;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] east;
        logic signed [DW-1:0] diag;
    } entry_t;

    function automatic logic [2*COORD_BITS-1:0] from_zone0(
        input zone_t                z,
        input logic signed [CW-1:0] u,
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] nu;
        logic signed [CW-1:0] nv;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        nu = -u;
        nv = -v;
        case (z)
            ZONE_0:  begin x = u;  y = v;  end
            ZONE_1:  begin x = v;  y = u;  end
            ZONE_2:  begin x = nv; y = u;  end
            ZONE_3:  begin x = nu; y = v;  end
            ZONE_4:  begin x = nu; y = nv; end
            ZONE_5:  begin x = nv; y = nu; end
            ZONE_6:  begin x = v;  y = nu; end
            ZONE_7:  begin x = u;  y = nv; end
            default: begin x = u;  y = nv; end
        endcase
        return {y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    entry_t head;

    // Line state
    logic                 active_reg;
    logic                 active_next;
    logic signed [CW-1:0] walk_x_reg;
    logic signed [CW-1:0] walk_x_next;
    logic signed [CW-1:0] walk_y_reg;
    logic signed [CW-1:0] walk_y_next;
    logic signed [CW-1:0] stop_x_reg;
    logic signed [DW-1:0] dec_reg;
    logic signed [DW-1:0] dec_next;
    logic signed [DW-1:0] east_reg;
    logic signed [DW-1:0] diag_reg;
    zone_t                zone_reg;

    // Output register
    logic                 tvalid_reg;
    logic                 tvalid_next;
    logic [OUT_W-1:0]     tdata_reg;
    logic [OUT_W-1:0]     tdata_next;
    logic                 tuser_reg;
    logic                 tuser_next;
    logic                 tlast_reg;
    logic                 tlast_next;

    // Working values: the queued start or the running line
    logic                 is_start;
    logic                 take;
    logic                 cur_active;
    logic signed [CW-1:0] cur_wx;
    logic signed [CW-1:0] cur_wy;
    logic signed [CW-1:0] cur_stop;
    logic signed [DW-1:0] cur_dec;
    logic signed [DW-1:0] cur_east;
    logic signed [DW-1:0] cur_diag;
    zone_t                cur_zone;
    logic                 fin;
    logic                 advance;
    logic [2*COORD_BITS-1:0] pix;

    assign head      = entry_t'(pop_data);
    assign pop_ready = !tvalid_reg || m_tready;
    assign take      = pop_valid && pop_ready;
    assign is_start  = head.kind == FUNC_START;

    always_comb
    begin
        if (is_start)
        begin
            cur_active = 1'b1;
            cur_wx     = head.u0;
            cur_wy     = head.v0;
            cur_stop   = head.u1;
            cur_dec    = head.d0;
            cur_east   = head.east;
            cur_diag   = head.diag;
            cur_zone   = head.zone;
        end
        else
        begin
            cur_active = active_reg;
            cur_wx     = walk_x_reg;
            cur_wy     = walk_y_reg;
            cur_stop   = stop_x_reg;
            cur_dec    = dec_reg;
            cur_east   = east_reg;
            cur_diag   = diag_reg;
            cur_zone   = zone_reg;
        end
    end

    assign fin     = cur_wx >= cur_stop;
    assign advance = cur_active && !fin;
    assign pix     = from_zone0(cur_zone, cur_wx, cur_wy);

    always_comb
    begin
        active_next = cur_active && !fin;
        walk_x_next = cur_wx;
        walk_y_next = cur_wy;
        dec_next    = cur_dec;
        if (advance)
        begin
            walk_x_next = cur_wx + CW'(1);
            if (cur_dec[DW-1])
            begin
                dec_next = cur_dec + cur_east;
            end
            else
            begin
                dec_next    = cur_dec + cur_diag;
                walk_y_next = cur_wy + CW'(1);
            end
        end
    end

    always_comb
    begin
        if (cur_active)
        begin
            tuser_next = 1'b1;
            tdata_next = OUT_W'({cur_zone, pix});
            tlast_next = fin;
        end
        else
        begin
            tuser_next = 1'b0;
            tdata_next = '0;
            tlast_next = 1'b0;
        end
    end

    always_comb
    begin
        if (take)
            tvalid_next = 1'b1;
        else if (m_tready)
            tvalid_next = 1'b0;
        else
            tvalid_next = tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
            if (take)
                active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            dec_reg    <= dec_next;
            tdata_reg  <= tdata_next;
            tuser_reg  <= tuser_next;
            tlast_reg  <= tlast_next;
            if (is_start)
            begin
                stop_x_reg <= head.u1;
                east_reg   <= head.east;
                diag_reg   <= head.diag;
                zone_reg   <= head.zone;
            end
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== sv/mlr_checker.sv =====
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks on the rasteriser output, bound to the top level.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_assert.svh"

module mlr_checker
    import mlr_pkg::*;
#(
    parameter  int COORD_BITS = COORD_BITS_DEF,
    localparam int OUT_W      = ((2 * COORD_BITS + 3 + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    // An idle tick carries an all-zero result
    `MLR_ASSERT(a_idle_tick_zero, m_tvalid && !m_tuser |-> m_tdata == '0 && !m_tlast, "idle tick with nonzero payload")

    // Only a real pixel can close a line
    `MLR_ASSERT(a_last_is_pixel, m_tvalid && m_tlast |-> m_tuser, "last flagged on an idle tick")

    // Hold a stalled transaction
    `MLR_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed under stall")

    // Nothing leaves the edge after reset is seen
    `MLR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "output valid straight after reset")

endmodule

bind midpoint_line_rasterizer mlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_mlr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
